### sv/lrmcw_pkg.sv
`default_nettype none
package lrmcw_pkg;

  // Value format
  localparam int VW = 32;                  // value width
  localparam int FB = 16;                  // fraction bits

  // Derived datapath widths
  localparam int DW     = VW + 1;          // span and offset width (signed)
  localparam int XW     = DW + 1;          // mapped offset width (signed)
  localparam int NUM_W  = XW + DW + 1;     // numerator width (signed)
  localparam int DIV_W  = DW + FB;         // divisor magnitude width
  localparam int STEP   = 4;               // quotient bits per divider stage
  localparam int WSTG   = (DW + STEP - 1) / STEP;
  localparam int WDVD_W = WSTG * STEP;
  localparam int MSTG   = (NUM_W + STEP - 1) / STEP;
  localparam int MDVD_W = MSTG * STEP;
  localparam int QR_W   = MDVD_W + 1;
  localparam int QS_W   = QR_W + FB;

  // Configuration port
  localparam int DATA_W   = (VW > 32) ? 64 : 32;
  localparam int ADDR_LSB = (VW > 32) ? 3 : 2;
  localparam int IDX_W    = 3;
  localparam int ADDR_W   = ADDR_LSB + IDX_W;

  localparam logic [IDX_W-1:0] REG_IN_LOW   = 3'd0;
  localparam logic [IDX_W-1:0] REG_IN_HIGH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_OUT_LOW  = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUT_HIGH = 3'd3;
  localparam logic [IDX_W-1:0] REG_MODE     = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROUND    = 3'd5;
  localparam logic [IDX_W-1:0] REG_RANGES   = 3'd6;

  // Map modes
  localparam logic [1:0] MODE_SCALE = 2'd0;
  localparam logic [1:0] MODE_CLAMP = 2'd1;
  localparam logic [1:0] MODE_WRAP  = 2'd2;

endpackage
`default_nettype wire

### sv/linear_range_map_clamp_wrap.sv
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+-----------------------------
// input     | sample_value_i, is_numeric_i                 | start high while busy low
// result    | mapped_value_o, fault_o                      | valid_o high for one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata | APB, pready always high
//
// One item enters per cycle; busy stays low. Values are Q16.16. Each item passes
// through the two restoring dividers (wrap modulo and final quotient), which
// retire four bits per stage.
// Items with is_numeric_i low, or while ranges_q is low, are dropped at entry.
// Reset clears the valid bits and the registers to their defaults.
// Results cannot be held off; the pipeline never stalls.
`default_nettype none
module linear_range_map_clamp_wrap (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [lrmcw_pkg::VW-1:0]              sample_value_i,
  input  wire logic                                  is_numeric_i,
  output logic                                       valid_o,
  output logic [lrmcw_pkg::VW-1:0]                   mapped_value_o,
  output logic                                       fault_o,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [lrmcw_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [lrmcw_pkg::DATA_W-1:0]          pwdata,
  output logic [lrmcw_pkg::DATA_W-1:0]               prdata,
  output logic                                       pready
);

  localparam int VW     = lrmcw_pkg::VW;
  localparam int FB     = lrmcw_pkg::FB;
  localparam int DW     = lrmcw_pkg::DW;
  localparam int XW     = lrmcw_pkg::XW;
  localparam int NUM_W  = lrmcw_pkg::NUM_W;
  localparam int DIV_W  = lrmcw_pkg::DIV_W;
  localparam int STEP   = lrmcw_pkg::STEP;
  localparam int WSTG   = lrmcw_pkg::WSTG;
  localparam int WDVD_W = lrmcw_pkg::WDVD_W;
  localparam int MSTG   = lrmcw_pkg::MSTG;
  localparam int MDVD_W = lrmcw_pkg::MDVD_W;
  localparam int QR_W   = lrmcw_pkg::QR_W;
  localparam int QS_W   = lrmcw_pkg::QS_W;
  localparam int DATA_W = lrmcw_pkg::DATA_W;
  localparam int LAT    = WSTG + MSTG + 6;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [VW-1:0] in_low_q, in_high_q, out_low_q, out_high_q;
  logic [1:0]    map_mode_q;
  logic          round_q, ranges_q;
  logic          cfg_wr;
  logic [lrmcw_pkg::IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[lrmcw_pkg::ADDR_W-1:lrmcw_pkg::ADDR_LSB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_low_q   <= '0;
      in_high_q  <= VW'(1) << FB;
      out_low_q  <= '0;
      out_high_q <= VW'(1) << FB;
      map_mode_q <= lrmcw_pkg::MODE_SCALE;
      round_q    <= 1'b0;
      ranges_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lrmcw_pkg::REG_IN_LOW:   in_low_q   <= pwdata[VW-1:0];
        lrmcw_pkg::REG_IN_HIGH:  in_high_q  <= pwdata[VW-1:0];
        lrmcw_pkg::REG_OUT_LOW:  out_low_q  <= pwdata[VW-1:0];
        lrmcw_pkg::REG_OUT_HIGH: out_high_q <= pwdata[VW-1:0];
        lrmcw_pkg::REG_MODE:     map_mode_q <= pwdata[1:0];
        lrmcw_pkg::REG_ROUND:    round_q    <= pwdata[0];
        lrmcw_pkg::REG_RANGES:   ranges_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lrmcw_pkg::REG_IN_LOW:   prdata = DATA_W'(in_low_q);
      lrmcw_pkg::REG_IN_HIGH:  prdata = DATA_W'(in_high_q);
      lrmcw_pkg::REG_OUT_LOW:  prdata = DATA_W'(out_low_q);
      lrmcw_pkg::REG_OUT_HIGH: prdata = DATA_W'(out_high_q);
      lrmcw_pkg::REG_MODE:     prdata = DATA_W'(map_mode_q);
      lrmcw_pkg::REG_ROUND:    prdata = DATA_W'(round_q);
      lrmcw_pkg::REG_RANGES:   prdata = DATA_W'(ranges_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Range terms. The user must change the registers only with the pipeline
  // empty; the block does not enforce this, and every stage reads them directly.
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] lo_x, hi_x, d_s, ospan_s;
  logic        [DW-1:0] d_mag;
  logic                 d_neg, d_zero;
  logic     [DIV_W-1:0] div_mag;

  always_comb begin
    lo_x    = DW'(signed'(in_low_q));
    hi_x    = DW'(signed'(in_high_q));
    d_s     = hi_x - lo_x;
    ospan_s = DW'(signed'(out_high_q)) - DW'(signed'(out_low_q));
    d_neg   = d_s[DW-1];
    d_zero  = (d_s == '0);
    d_mag   = d_neg ? DW'(-d_s) : DW'(d_s);
    div_mag = round_q ? {d_mag, {FB{1'b0}}} : DIV_W'(d_mag);
  end

  // ---------------------------------------------------------------------
  // Entry: take the offset from the input minimum, split sign and size.
  // ---------------------------------------------------------------------
  logic                 acc;
  logic signed [DW-1:0] a_s;

  assign busy = 1'b0;
  assign acc  = start && !busy && ranges_q && is_numeric_i;
  assign a_s  = DW'(signed'(sample_value_i)) - lo_x;

  // Wrap divider: remainder of |n - lo| by |span|
  logic              w_v_q   [WSTG+1];
  logic [WDVD_W-1:0] w_dvd_q [WSTG+1];
  logic [DW:0]       w_rem_q [WSTG+1];
  logic              w_neg_q [WSTG+1];
  logic [VW-1:0]     w_n_q   [WSTG+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_v_q[0] <= 1'b0;
    end else begin
      w_v_q[0] <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    w_dvd_q[0] <= WDVD_W'(a_s[DW-1] ? DW'(-a_s) : DW'(a_s));
    w_rem_q[0] <= '0;
    w_neg_q[0] <= a_s[DW-1];
    w_n_q[0]   <= sample_value_i;
  end

  for (genvar g = 0; g < WSTG; g++) begin : g_wrap
    logic [DW:0]       rem_c;
    logic [WDVD_W-1:0] dvd_c;

    always_comb begin
      rem_c = w_rem_q[g];
      dvd_c = w_dvd_q[g];
      for (int i = 0; i < STEP; i++) begin
        rem_c = {rem_c[DW-1:0], dvd_c[WDVD_W-1]};
        dvd_c = {dvd_c[WDVD_W-2:0], 1'b0};
        if (rem_c >= {1'b0, d_mag}) begin
          rem_c    = rem_c - {1'b0, d_mag};
          dvd_c[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        w_v_q[g+1] <= 1'b0;
      end else begin
        w_v_q[g+1] <= w_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      w_dvd_q[g+1] <= dvd_c;
      w_rem_q[g+1] <= rem_c;
      w_neg_q[g+1] <= w_neg_q[g];
      w_n_q[g+1]   <= w_n_q[g];
    end
  end

  // ---------------------------------------------------------------------
  // Fold: pick the offset per mode (scale, clamp, or modulo with the span's sign).
  // ---------------------------------------------------------------------
  logic        [DW-1:0] r_m;
  logic signed [XW-1:0] r_s, n_x, nc_x, lo_xx, hi_xx, x_d, x_q;
  logic                 x_v_q;

  always_comb begin
    r_m   = w_rem_q[WSTG][DW-1:0];
    lo_xx = XW'(signed'(in_low_q));
    hi_xx = XW'(signed'(in_high_q));
    n_x   = XW'(signed'(w_n_q[WSTG]));
    r_s   = w_neg_q[WSTG] ? -XW'(r_m) : XW'(r_m);
    if (r_m != '0 && w_neg_q[WSTG] != d_neg) begin
      r_s = r_s + XW'(d_s);
    end
    nc_x = n_x;
    if (nc_x < lo_xx) begin
      nc_x = lo_xx;
    end
    if (nc_x > hi_xx) begin
      nc_x = hi_xx;
    end
    case (map_mode_q)
      lrmcw_pkg::MODE_CLAMP: x_d = nc_x - lo_xx;
      lrmcw_pkg::MODE_WRAP:  x_d = r_s;
      default:               x_d = n_x - lo_xx;
    endcase
  end

  // Products, then numerator with the span sign folded in
  logic signed [NUM_W-1:0] p1_d, p2_d, p1_q, p2_q, num_d, num_q;
  logic                    p_v_q, s_v_q;

  assign p1_d  = x_q * ospan_s;
  assign p2_d  = signed'(out_low_q) * d_s;
  assign num_d = d_neg ? -(p1_q + p2_q) : (p1_q + p2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_v_q <= 1'b0;
      p_v_q <= 1'b0;
      s_v_q <= 1'b0;
    end else begin
      x_v_q <= w_v_q[WSTG];
      p_v_q <= x_v_q;
      s_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    num_q <= num_d;
  end

  // ---------------------------------------------------------------------
  // Main divider: |num| by |span| (shifted when rounding to integers).
  // ---------------------------------------------------------------------
  logic              m_v_q   [MSTG+1];
  logic [MDVD_W-1:0] m_dvd_q [MSTG+1];
  logic [DIV_W:0]    m_rem_q [MSTG+1];
  logic              m_neg_q [MSTG+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q[0] <= 1'b0;
    end else begin
      m_v_q[0] <= s_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_dvd_q[0] <= MDVD_W'(num_q[NUM_W-1] ? -num_q : num_q);
    m_rem_q[0] <= '0;
    m_neg_q[0] <= num_q[NUM_W-1];
  end

  for (genvar g = 0; g < MSTG; g++) begin : g_main
    logic [DIV_W:0]    rem_c;
    logic [MDVD_W-1:0] dvd_c;

    always_comb begin
      rem_c = m_rem_q[g];
      dvd_c = m_dvd_q[g];
      for (int i = 0; i < STEP; i++) begin
        rem_c = {rem_c[DIV_W-1:0], dvd_c[MDVD_W-1]};
        dvd_c = {dvd_c[MDVD_W-2:0], 1'b0};
        if (rem_c >= {1'b0, div_mag}) begin
          rem_c    = rem_c - {1'b0, div_mag};
          dvd_c[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        m_v_q[g+1] <= 1'b0;
      end else begin
        m_v_q[g+1] <= m_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      m_dvd_q[g+1] <= dvd_c;
      m_rem_q[g+1] <= rem_c;
      m_neg_q[g+1] <= m_neg_q[g];
    end
  end

  // ---------------------------------------------------------------------
  // Round half away from zero, rescale, saturate; a zero span gives zero and a fault.
  // ---------------------------------------------------------------------
  logic              inc;
  logic [QR_W-1:0]   qr_d, qr_q;
  logic              qr_neg_q, qr_v_q;
  logic [QS_W-1:0]   qs, lim;
  logic [VW-1:0]     mag_v, res_d;
  logic              fault_d;

  assign inc  = {m_rem_q[MSTG], 1'b0} >= {2'b00, div_mag};
  assign qr_d = QR_W'(m_dvd_q[MSTG]) + QR_W'(inc);

  always_comb begin
    qs    = round_q ? {qr_q, {FB{1'b0}}} : QS_W'(qr_q);
    lim   = QS_W'(1) << (VW - 1);
    mag_v = qs[VW-1:0];
    res_d = qr_neg_q ? -mag_v : mag_v;
    fault_d = 1'b0;
    if (d_zero) begin
      res_d   = '0;
      fault_d = 1'b1;
    end else if (!qr_neg_q && qs >= lim) begin
      res_d   = {1'b0, {(VW-1){1'b1}}};
      fault_d = 1'b1;
    end else if (qr_neg_q && qs > lim) begin
      res_d   = {1'b1, {(VW-1){1'b0}}};
      fault_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qr_v_q  <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      qr_v_q  <= m_v_q[MSTG];
      valid_o <= qr_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    qr_q           <= qr_d;
    qr_neg_q       <= m_neg_q[MSTG];
    mapped_value_o <= res_d;
    fault_o        <= fault_d;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == $past(w_v_q[0], LAT))
    else $error("result strobe does not follow entry by the pipeline depth");

  a_wrap_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_v_q && map_mode_q == lrmcw_pkg::MODE_WRAP && !d_zero) |->
      (x_q == '0 || x_q[XW-1] == d_neg))
    else $error("folded offset has the wrong sign");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_v_q[MSTG] && !d_zero) |-> (m_rem_q[MSTG] < {1'b0, div_mag}))
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire
